>>> rtl/core/rsbn_pkg.sv
// rsbn_pkg: shared constants and types for the record sort block
// no dependencies
package rsbn_pkg;

  localparam int NAME_W = 160;
  localparam int MOBILE_W = 34;
  localparam int BILL_W = 32;

  // name compare request and answer between sequencer and compare unit
  typedef struct packed {
    logic start;
  } cmp_req_t;

  typedef struct packed {
    logic done;
    logic greater;
  } cmp_rsp_t;

endpackage

>>> rtl/core/rsbn_cmp.sv
// rsbn_cmp: iterative strcmp-style name compare, one byte per cycle
// depends on rsbn_pkg
module rsbn_cmp #(
  parameter int NAME_BYTES = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rsbn_pkg::cmp_req_t        req_i,
  input  logic [rsbn_pkg::NAME_W-1:0] a_i,
  input  logic [rsbn_pkg::NAME_W-1:0] b_i,
  output rsbn_pkg::cmp_rsp_t        rsp_o
);

  localparam int KW = $clog2(NAME_BYTES + 1);

  logic          busy_q, busy_d;
  logic [KW-1:0] k_q, k_d;
  logic          done_q, done_d, gt_q, gt_d;
  logic [7:0]    x, y;

  // byte k of each name, byte 0 at the top
  assign x = a_i[rsbn_pkg::NAME_W-1 - 8*k_q -: 8];
  assign y = b_i[rsbn_pkg::NAME_W-1 - 8*k_q -: 8];

  // compare step
  always_comb begin
    busy_d = busy_q;
    k_d = k_q;
    done_d = 1'b0;
    gt_d = gt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      k_d = '0;
    end else if (busy_q) begin
      if (k_q == KW'(NAME_BYTES)) begin
        busy_d = 1'b0; done_d = 1'b1; gt_d = 1'b0;
      end else if (x != y) begin
        busy_d = 1'b0; done_d = 1'b1; gt_d = (x > y);
      end else if (x == 8'd0) begin
        busy_d = 1'b0; done_d = 1'b1; gt_d = 1'b0;
      end else begin
        k_d = k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q <= '0;
      done_q <= 1'b0;
      gt_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      k_q <= k_d;
      done_q <= done_d;
      gt_q <= gt_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.greater = gt_q;

  // a compare ends no more than one step past the last byte
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> k_q <= KW'(NAME_BYTES)) else $error("compare index past name");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("start did not arm compare");

endmodule

>>> rtl/core/record_sort_by_name_top.sv
// record_sort_by_name_top: collects records, insertion-sorts them by name, emits in order
// depends on rsbn_pkg and rsbn_cmp
//
//  channel | handshake               | payload
//  input   | in_valid_i/in_stall_o   | name_bytes_*, mobile_number, bill_amount, last_record
//  output  | out_valid_o/out_stall_i | out_name_*, out_mobile, out_bill, last_result,
//          |                         | records_dropped
//
// records are taken back to back while loading; the last record starts the sort
// the sort is a stable insertion sort on an index list kept in a memory with
// registered reads; each name compare runs on the shared compare unit at one byte
// a cycle, after the fetch of the neighbor name in S_FETCH and the start in S_CMP
// a set of n records costs up to about n*n/2 compares; each result is read in S_RD
// and then shown in S_OUT; output stall simply holds the current result; no input
// is taken while sorting or emitting; reset clears the state, counters and flags
// but not the memories
module record_sort_by_name_top #(
  parameter int MAX_RECORDS = 64,
  parameter int NAME_BYTES = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] name_bytes_first_i,
  input  logic [63:0] name_bytes_middle_i,
  input  logic [31:0] name_bytes_tail_i,
  input  logic [33:0] mobile_number_i,
  input  logic signed [31:0] bill_amount_i,
  input  logic        last_record_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_name_first_o,
  output logic [63:0] out_name_middle_o,
  output logic [31:0] out_name_tail_o,
  output logic [33:0] out_mobile_o,
  output logic signed [31:0] out_bill_o,
  output logic        last_result_o,
  output logic        records_dropped_o
);

  localparam int IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = $clog2(MAX_RECORDS + 1);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_CUR = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_CMP = 4'd4;
  localparam logic [3:0] S_WAIT = 4'd5;
  localparam logic [3:0] S_PLACE = 4'd6;
  localparam logic [3:0] S_RD = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  typedef logic [rsbn_pkg::NAME_W-1:0] name_t;
  typedef logic [rsbn_pkg::MOBILE_W+rsbn_pkg::BILL_W-1:0] data_t;

  // record memories and the index list
  name_t   name_mem [MAX_RECORDS];
  data_t   data_mem [MAX_RECORDS];
  logic [IW-1:0] ord_mem [MAX_RECORDS];

  logic [3:0]    state_q;
  logic [CW-1:0] count_q, i_q, j_q, o_q;
  logic [CW-1:0] j_m1, j_m2, o_p1;
  logic          ovf_q, dropped_q;
  logic [IW-1:0] cur_q, prev_q, ord_rd_q;
  logic          ord_we;
  logic [IW-1:0] ord_waddr, ord_wdata, ord_raddr;
  name_t         cur_name_q, cmp_name_q, out_name_q;
  data_t         out_data_q;
  logic          out_last_q;
  rsbn_pkg::cmp_req_t req;
  rsbn_pkg::cmp_rsp_t rsp;
  logic          in_acc;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc = in_valid_i && !in_stall_o;

  rsbn_cmp #(.NAME_BYTES(NAME_BYTES)) u_cmp (
    .clk_i, .rst_ni, .req_i(req), .a_i(cmp_name_q), .b_i(cur_name_q), .rsp_o(rsp)
  );

  assign req.start = (state_q == S_CMP);

  assign j_m1 = j_q - CW'(1);
  assign j_m2 = j_q - CW'(2);
  assign o_p1 = o_q + CW'(1);

  // record memory write on load
  always_ff @(posedge clk_i) begin
    if (in_acc && count_q < CW'(MAX_RECORDS)) begin
      name_mem[count_q[IW-1:0]] <= {name_bytes_first_i, name_bytes_middle_i,
                                    name_bytes_tail_i};
      data_mem[count_q[IW-1:0]] <= {mobile_number_i, bill_amount_i};
    end
  end

  // index list port select: one read and one write a cycle
  always_comb begin
    ord_we = 1'b0;
    ord_waddr = j_q[IW-1:0];
    ord_wdata = cur_q;
    ord_raddr = o_q[IW-1:0];
    case (state_q)
      S_LOAD: begin
        ord_we = in_acc && (count_q < CW'(MAX_RECORDS));
        ord_waddr = count_q[IW-1:0];
        ord_wdata = count_q[IW-1:0];
      end
      S_INIT: ord_raddr = (i_q < count_q) ? i_q[IW-1:0] : o_q[IW-1:0];
      S_CUR: ord_raddr = j_m1[IW-1:0];
      S_WAIT: begin
        ord_raddr = j_m2[IW-1:0];
        if (rsp.done) begin
          ord_we = 1'b1;
          ord_wdata = rsp.greater ? prev_q : cur_q;
        end
      end
      S_PLACE: ord_we = 1'b1;
      S_OUT: ord_raddr = o_p1[IW-1:0];
      default: ;
    endcase
  end

  // index list memory
  always_ff @(posedge clk_i) begin
    if (ord_we)
      ord_mem[ord_waddr] <= ord_wdata;
    ord_rd_q <= ord_mem[ord_raddr];
  end

  // registered memory reads
  always_ff @(posedge clk_i) begin
    if (state_q == S_CUR)
      cur_name_q <= name_mem[ord_rd_q];
    if (state_q == S_FETCH)
      cmp_name_q <= name_mem[ord_rd_q];
    if (state_q == S_RD) begin
      out_name_q <= name_mem[ord_rd_q];
      out_data_q <= data_mem[ord_rd_q];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      ovf_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      o_q <= '0;
      cur_q <= '0;
      prev_q <= '0;
      dropped_q <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: if (in_acc) begin
          if (count_q < CW'(MAX_RECORDS)) begin
            count_q <= count_q + 1'b1;
          end else begin
            ovf_q <= 1'b1;
          end
          if (last_record_i) begin
            dropped_q <= ovf_q || (count_q >= CW'(MAX_RECORDS));
            i_q <= CW'(1);
            o_q <= '0;
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          if (i_q >= count_q) begin
            state_q <= S_RD;
          end else begin
            j_q <= i_q;
            state_q <= S_CUR;
          end
        end
        S_CUR: begin
          cur_q <= ord_rd_q;
          state_q <= S_FETCH;
        end
        S_FETCH: begin
          prev_q <= ord_rd_q;
          state_q <= S_CMP;
        end
        S_CMP: state_q <= S_WAIT;
        S_WAIT: if (rsp.done) begin
          if (rsp.greater) begin
            j_q <= j_m1;
            if (j_q == CW'(1)) begin
              state_q <= S_PLACE;
            end else begin
              state_q <= S_FETCH;
            end
          end else begin
            i_q <= i_q + 1'b1;
            state_q <= S_INIT;
          end
        end
        S_PLACE: begin
          i_q <= i_q + 1'b1;
          state_q <= S_INIT;
        end
        S_RD: begin
          if (o_q >= count_q) begin
            count_q <= '0;
            ovf_q <= 1'b0;
            state_q <= S_LOAD;
          end else begin
            out_last_q <= (o_q + 1'b1 == count_q);
            state_q <= S_OUT;
          end
        end
        S_OUT: if (!out_stall_i) begin
          o_q <= o_p1;
          state_q <= S_RD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // result port
  assign out_valid_o = (state_q == S_OUT);
  assign out_name_first_o = out_name_q[159:96];
  assign out_name_middle_o = out_name_q[95:32];
  assign out_name_tail_o = out_name_q[31:0];
  assign out_mobile_o = out_data_q[65:32];
  assign out_bill_o = out_data_q[31:0];
  assign last_result_o = out_last_q;
  assign records_dropped_o = dropped_q;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_RECORDS)) else $error("record count over capacity");
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_LOAD |-> in_stall_o) else $error("input open while sorting");
  a_out_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> o_q < count_q) else $error("emitting past set end");
  a_sort_j: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |-> (j_q != '0 && j_q <= i_q)) else $error("bad insert slot");
  a_place_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PLACE |-> j_q == '0) else $error("front insert off slot zero");

endmodule
